>>> rtl/core/smf_pkg.sv
// smf_pkg: shared types for the set membership filter
// request actions and the token that walks the compare chain
// no dependencies
`default_nettype none

package smf_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  // one request in flight along the chain
  typedef struct packed {
    logic               vld;
    logic [1:0]         act;
    logic [VALUE_W-1:0] value;
    logic               hit;     // some cell already matched the query
    logic               placed;  // a cell already took the load
  } token_t;

endpackage

`default_nettype wire

>>> rtl/core/smf_channels.sv
// smf_req_if / smf_res_if: valid/ready channels of the set membership filter
// depends on smf_pkg for field widths
`default_nettype none

interface smf_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         action;
  logic signed [smf_pkg::VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface smf_res_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic signed [smf_pkg::VALUE_W-1:0] echo_value;
  logic [smf_pkg::COUNT_W-1:0]        match_total;
  logic                               store_full_drop;

  modport source (output valid, output found, output echo_value, output match_total,
                  output store_full_drop, input ready);
  modport sink (input valid, input found, input echo_value, input match_total,
                input store_full_drop, output ready);
endinterface

`default_nettype wire

>>> rtl/core/smf_cell.sv
// smf_cell: one slot of the reference store plus one token stage
// compares queries, takes the first load that finds it empty, empties on clear
// depends on smf_pkg
`default_nettype none

module smf_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire smf_pkg::token_t tok_in,
  output smf_pkg::token_t      tok_out
);

  logic                  slot_vld;
  logic                  slot_vld_next;
  logic [DATA_WIDTH-1:0] slot_data;
  logic [63:0]           ext;
  logic [DATA_WIDTH-1:0] key;
  logic                  take;
  logic                  is_clear;
  logic                  is_query;
  smf_pkg::token_t       tok;
  smf_pkg::token_t       tok_next;

  // sign-extend, then keep the stored width
  assign ext = {{(64 - smf_pkg::VALUE_W){tok_in.value[smf_pkg::VALUE_W-1]}}, tok_in.value};
  assign key = ext[DATA_WIDTH-1:0];

  assign is_clear = tok_in.vld && (tok_in.act == smf_pkg::ACT_CLEAR);
  assign is_query = tok_in.vld && (tok_in.act == smf_pkg::ACT_QUERY);
  assign take = tok_in.vld && (tok_in.act == smf_pkg::ACT_LOAD) && !tok_in.placed && !slot_vld;

  always_comb begin
    tok_next        = tok_in;
    tok_next.placed = tok_in.placed | take;
    tok_next.hit    = tok_in.hit | (is_query && slot_vld && (slot_data == key));
  end

  always_comb begin
    slot_vld_next = slot_vld;
    if (is_clear) begin
      slot_vld_next = 1'b0;
    end else if (take) begin
      slot_vld_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= 1'b0;
      tok      <= '0;
    end else if (adv) begin
      slot_vld <= slot_vld_next;
      tok      <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      slot_data <= key;
    end
  end

  assign tok_out = tok;

endmodule

`default_nettype wire

>>> rtl/core/smf_result.sv
// smf_result: match counter and result register at the end of the chain
// drives the result channel and the chain advance
// depends on smf_pkg and smf_res_if
`default_nettype none

module smf_result (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire smf_pkg::token_t tok,
  output logic                 adv,
  smf_res_if.source            res
);

  logic [smf_pkg::COUNT_W-1:0] match_counter;
  logic [smf_pkg::COUNT_W-1:0] match_counter_next;
  logic                        hit_q;
  logic                        is_clear;
  logic                        is_load;

  // the chain moves when the result register is empty or being drained
  assign adv = !res.valid || res.ready;

  assign is_clear = tok.vld && (tok.act == smf_pkg::ACT_CLEAR);
  assign is_load  = tok.vld && (tok.act == smf_pkg::ACT_LOAD);
  assign hit_q    = tok.vld && (tok.act == smf_pkg::ACT_QUERY) && tok.hit;

  always_comb begin
    match_counter_next = match_counter;
    if (is_clear) begin
      match_counter_next = '0;
    end else if (hit_q && (match_counter != smf_pkg::COUNT_MAX)) begin
      match_counter_next = match_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_counter <= '0;
      res.valid     <= 1'b0;
    end else if (adv) begin
      match_counter <= match_counter_next;
      res.valid     <= tok.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.found           <= hit_q;
      res.echo_value      <= hit_q ? tok.value : '0;
      res.match_total     <= match_counter_next;
      // a load that left the chain unplaced found every slot taken
      res.store_full_drop <= is_load && !tok.placed;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/set_membership_filter.sv
// set_membership_filter: chain of SET_DEPTH store cells and a result register
// throughput: one request per cycle; each cell registers the token it hands on,
// so the whole chain moves in lockstep and stalls only on result backpressure
// reset: empties every slot, zeroes the match count and drops tokens in flight
`default_nettype none

module set_membership_filter #(
  parameter int unsigned SET_DEPTH  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  smf_req_if.sink   req,
  smf_res_if.source res
);

  smf_pkg::token_t link [SET_DEPTH+1];
  logic            adv;

  assign req.ready = adv;

  always_comb begin
    link[0].vld    = req.valid && adv;
    link[0].act    = req.action;
    link[0].value  = req.value;
    link[0].hit    = 1'b0;
    link[0].placed = 1'b0;
  end

  // slots fill in order, so the occupied cells form the store count
  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    smf_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  smf_result u_result (
    .clk (clk),
    .rst (rst),
    .tok (link[SET_DEPTH]),
    .adv (adv),
    .res (res)
  );

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (res.valid && !res.ready))
    else $error("request side stalled without result backpressure");

  a_found_counts: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.found) |-> (res.match_total != '0))
    else $error("match reported with zero match total");

  a_drop_not_found: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.store_full_drop) |-> !res.found)
    else $error("dropped load reported as a match");

  a_miss_echo_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.found) |-> (res.echo_value == '0))
    else $error("echo value set without a match");

endmodule

`default_nettype wire

>>> dv/set_membership_filter_test.sv
// set_membership_filter_test: self-checking bench for the set membership filter
// drives loads, queries and clears over smf_req_if and checks every response
// against a behavioral model kept here or a typed expected outcome; depends on smf_pkg and smf_channels

module set_membership_filter_test;

  localparam int unsigned STORE_DEPTH  = 64;
  localparam int          RANDOM_ITEMS = 1300;
  localparam int          DRAIN_CYCLES = STORE_DEPTH + 40;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          N_DIRECTED   = 19;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;

  typedef struct packed {
    logic                        found;
    logic [smf_pkg::VALUE_W-1:0] echo;
    logic [smf_pkg::COUNT_W-1:0] total;
    logic                        drop;
  } outcome_t;

  typedef struct packed {
    logic [1:0]                  act;
    logic [smf_pkg::VALUE_W-1:0] val;
    logic                        typed;
    outcome_t                    want;
  } stim_row_t;

  logic clk;
  logic rst;

  smf_req_if req_bus ();
  smf_res_if res_bus ();

  set_membership_filter #(
    .SET_DEPTH (STORE_DEPTH),
    .DATA_WIDTH(smf_pkg::VALUE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .res(res_bus)
  );

  // model state
  logic [smf_pkg::VALUE_W-1:0] stored_values[$];
  logic [smf_pkg::COUNT_W-1:0] match_count;

  outcome_t           pending_responses[$];
  int                 errors;
  int                 cycles;
  bit                 fast_mode;
  logic               typed_now;
  outcome_t           typed_want;
  stim_row_t          directed_rows[N_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic outcome_t filter_response(input logic [1:0] act,
                                               input logic [smf_pkg::VALUE_W-1:0] val);
    outcome_t r;
    bit       hit;
    r = '0;
    hit = 1'b0;
    case (act)
      smf_pkg::ACT_CLEAR: begin
        stored_values.delete();
        match_count = '0;
      end
      smf_pkg::ACT_LOAD: begin
        if (stored_values.size() < STORE_DEPTH) stored_values.push_back(val);
        else r.drop = 1'b1;
      end
      smf_pkg::ACT_QUERY: begin
        foreach (stored_values[i]) if (stored_values[i] == val) hit = 1'b1;
        if (hit) begin
          r.found = 1'b1;
          r.echo  = val;
          if (match_count != smf_pkg::COUNT_MAX) match_count = match_count + 1'b1;
        end
      end
      default: ;
    endcase
    r.total = match_count;
    return r;
  endfunction

  function automatic logic [smf_pkg::VALUE_W-1:0] pick_value(input bit narrow);
    // narrow values sit around zero so loads repeat and queries hit
    if (narrow) return $urandom_range(0, 15) - 32'd8;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [smf_pkg::VALUE_W-1:0] got,
                                 input logic [smf_pkg::VALUE_W-1:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
  endtask

  task automatic send_request(input logic [1:0] act, input logic [smf_pkg::VALUE_W-1:0] val,
                              input logic typed, input outcome_t want);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid  <= 1'b1;
    req_bus.action <= act;
    req_bus.value  <= val;
    typed_now      <= typed;
    typed_want     <= want;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
  endtask

  // request acceptance feeds the model, response acceptance is checked
  always @(posedge clk) begin
    outcome_t predicted;
    outcome_t seen;
    outcome_t oldest;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        predicted = filter_response(req_bus.action, req_bus.value);
        pending_responses.push_back(typed_now ? typed_want : predicted);
      end
      if (res_bus.valid && res_bus.ready) begin
        seen = '{res_bus.found, res_bus.echo_value, res_bus.match_total,
                 res_bus.store_full_drop};
        if (pending_responses.size() == 0) begin
          report_mismatch("response with none pending", seen.echo, '0);
        end else begin
          oldest = pending_responses.pop_front();
          if (seen.found !== oldest.found)
            report_mismatch("found", 32'(seen.found), 32'(oldest.found));
          if (seen.echo !== oldest.echo)
            report_mismatch("echo_value", seen.echo, oldest.echo);
          if (seen.total !== oldest.total)
            report_mismatch("match_total", 32'(seen.total), 32'(oldest.total));
          if (seen.drop !== oldest.drop)
            report_mismatch("store_full_drop", 32'(seen.drop), 32'(oldest.drop));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // response side backpressure
  initial begin
    int stall;
    @(negedge rst);
    @(negedge clk);
    forever begin
      stall = fast_mode ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
      @(negedge clk);
    end
  end

  initial begin
    int                          issued;
    int                          n;
    int                          kind;
    bit                          narrow;
    logic [1:0]                  act;
    logic [smf_pkg::VALUE_W-1:0] v;
    logic [smf_pkg::VALUE_W-1:0] loaded[$];

    rst            = 1'b1;
    req_bus.valid  = 1'b0;
    req_bus.action = smf_pkg::ACT_CLEAR;
    req_bus.value  = '0;
    res_bus.ready  = 1'b0;
    typed_now      = 1'b0;
    typed_want     = '0;
    match_count    = '0;
    errors         = 0;
    cycles         = 0;
    fast_mode      = 1'b0;
    issued         = 0;

    directed_rows[0]  = '{smf_pkg::ACT_QUERY, 32'h0000_0000, 1'b1,
                          '{1'b0, 32'h0, 16'd0, 1'b0}};
    directed_rows[1]  = '{smf_pkg::ACT_LOAD, 32'h7FFF_FFFF, 1'b1,
                          '{1'b0, 32'h0, 16'd0, 1'b0}};
    directed_rows[2]  = '{smf_pkg::ACT_LOAD, 32'h8000_0000, 1'b1,
                          '{1'b0, 32'h0, 16'd0, 1'b0}};
    directed_rows[3]  = '{smf_pkg::ACT_LOAD, 32'h0000_0000, 1'b1,
                          '{1'b0, 32'h0, 16'd0, 1'b0}};
    directed_rows[4]  = '{smf_pkg::ACT_LOAD, 32'hFFFF_FFFF, 1'b1,
                          '{1'b0, 32'h0, 16'd0, 1'b0}};
    directed_rows[5]  = '{smf_pkg::ACT_QUERY, 32'h8000_0000, 1'b1,
                          '{1'b1, 32'h8000_0000, 16'd1, 1'b0}};
    directed_rows[6]  = '{smf_pkg::ACT_QUERY, 32'h7FFF_FFFF, 1'b1,
                          '{1'b1, 32'h7FFF_FFFF, 16'd2, 1'b0}};
    directed_rows[7]  = '{smf_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1'b1,
                          '{1'b1, 32'hFFFF_FFFF, 16'd3, 1'b0}};
    directed_rows[8]  = '{smf_pkg::ACT_QUERY, 32'h0000_0000, 1'b1,
                          '{1'b1, 32'h0, 16'd4, 1'b0}};
    directed_rows[9]  = '{smf_pkg::ACT_QUERY, 32'h0000_0001, 1'b1,
                          '{1'b0, 32'h0, 16'd4, 1'b0}};
    directed_rows[10] = '{smf_pkg::ACT_QUERY, 32'h7FFF_FFFF, 1'b1,
                          '{1'b1, 32'h7FFF_FFFF, 16'd5, 1'b0}};
    directed_rows[11] = '{ACT_UNUSED, 32'h0000_007B, 1'b1, '{1'b0, 32'h0, 16'd5, 1'b0}};
    directed_rows[12] = '{smf_pkg::ACT_LOAD, 32'h0000_0000, 1'b1,
                          '{1'b0, 32'h0, 16'd5, 1'b0}};
    directed_rows[13] = '{smf_pkg::ACT_QUERY, 32'hFFFF_FFFE, 1'b1,
                          '{1'b0, 32'h0, 16'd5, 1'b0}};
    directed_rows[14] = '{smf_pkg::ACT_LOAD, 32'h5A5A_A5A5, 1'b0, '0};
    directed_rows[15] = '{smf_pkg::ACT_QUERY, 32'h5A5A_A5A5, 1'b0, '0};
    directed_rows[16] = '{smf_pkg::ACT_CLEAR, 32'hDEAD_BEEF, 1'b1,
                          '{1'b0, 32'h0, 16'd0, 1'b0}};
    directed_rows[17] = '{smf_pkg::ACT_QUERY, 32'h0000_0000, 1'b1,
                          '{1'b0, 32'h0, 16'd0, 1'b0}};
    directed_rows[18] = '{ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 16'd0, 1'b0}};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].act, directed_rows[i].val, directed_rows[i].typed,
                   directed_rows[i].want);

    // mostly clear/load/query sequences, some noise
    while (issued < RANDOM_ITEMS) begin
      fast_mode = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat (8) begin
          act = 2'($urandom_range(0, 3));
          send_request(act, pick_value(1'($urandom_range(0, 1))), 1'b0, '0);
          if (act != ACT_UNUSED) issued++;
        end
      end else begin
        narrow = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 4) != 0) begin
          send_request(smf_pkg::ACT_CLEAR, $urandom, 1'b0, '0);
          issued++;
          loaded.delete();
        end
        // now and then run past the store depth so loads get dropped
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 16);
        repeat (n) begin
          v = pick_value(narrow);
          loaded.push_back(v);
          send_request(smf_pkg::ACT_LOAD, v, 1'b0, '0);
          issued++;
        end
        n = $urandom_range(4, 30);
        repeat (n) begin
          kind = $urandom_range(0, 19);
          if (kind == 0) begin
            send_request(ACT_UNUSED, $urandom, 1'b0, '0);
          end else if (kind == 1) begin
            v = pick_value(narrow);
            loaded.push_back(v);
            send_request(smf_pkg::ACT_LOAD, v, 1'b0, '0);
            issued++;
          end else if (kind < 15 && loaded.size() > 0) begin
            send_request(smf_pkg::ACT_QUERY, loaded[$urandom_range(0, loaded.size() - 1)],
                         1'b0, '0);
            issued++;
          end else begin
            send_request(smf_pkg::ACT_QUERY, pick_value(narrow), 1'b0, '0);
            issued++;
          end
        end
      end
    end

    // full store and dropped loads at full rate
    fast_mode = 1'b1;
    loaded.delete();
    send_request(smf_pkg::ACT_CLEAR, '0, 1'b1, '0);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      v = 32'h8000_0000 + i * 32'h0204_0811;
      loaded.push_back(v);
      send_request(smf_pkg::ACT_LOAD, v, 1'b0, '0);
    end
    send_request(smf_pkg::ACT_LOAD, 32'h1234_5678, 1'b1, '{1'b0, 32'h0, 16'd0, 1'b1});
    send_request(smf_pkg::ACT_LOAD, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 16'd0, 1'b1});
    send_request(smf_pkg::ACT_QUERY, loaded[STORE_DEPTH-1], 1'b1,
                 '{1'b1, loaded[STORE_DEPTH-1], 16'd1, 1'b0});
    send_request(smf_pkg::ACT_QUERY, 32'h1234_5678, 1'b0, '0);
    fast_mode = 1'b0;
    send_request(smf_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 1'b1, '0);
    req_bus.valid <= 1'b0;

    wait (pending_responses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
